>>> rtl/core/rds_pkg.sv
// ----------------------------------------------------------------------------
// rds_pkg
// Shared types and constants of the reliable datagram sequencer: request and
// response payloads, configuration register indexes and status codes.
// ----------------------------------------------------------------------------
package rds_pkg;

	// Widths of the sequence and message length fields.
	localparam int SEQ_W = 31;
	localparam int LEN_W = 11;

	// Largest reliable message that the store holds, in bytes.
	localparam logic [LEN_W-1:0] MAX_MESSAGE = 11'd1450;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_PEER_IP        = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PEER_PORT      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CLIENT_PORT_ID = 2'd2;

	// Request function.
	typedef enum logic {
		FUNC_RECEIVE  = 1'b0,
		FUNC_TRANSMIT = 1'b1
	} rds_func_t;

	// Response status.
	typedef enum logic [2:0] {
		ST_SENT      = 3'd0,
		ST_ACCEPTED  = 3'd1,
		ST_WRONG_SRC = 3'd2,
		ST_STALE     = 3'd3,
		ST_OVERFLOW  = 3'd4,
		ST_NO_PEER   = 3'd5
	} rds_status_t;

	// One request: a received header or a transmit request.
	typedef struct packed {
		rds_func_t        func;
		logic [31:0]      src_ip;
		logic [15:0]      src_port;
		logic [31:0]      seq_word;
		logic [31:0]      ack_word;
		logic [LEN_W-1:0] pending_len;
		logic [11:0]      unreliable_len;
		logic             overflowed;
	} rds_req_t;

	// One response.
	typedef struct packed {
		rds_status_t      status;
		logic [31:0]      out_seq_word;
		logic [31:0]      out_ack_word;
		logic [15:0]      out_port_id;
		logic [LEN_W-1:0] reliable_bytes;
		logic             include_unreliable;
		logic             took_message;
	} rds_rsp_t;

	// Configuration registers as seen by the sequencing engine.
	typedef struct packed {
		logic [31:0] peer_ip;
		logic [15:0] peer_port;
		logic [15:0] client_port_id;
	} rds_cfg_t;

endpackage

>>> rtl/core/rds_if.sv
// ----------------------------------------------------------------------------
// rds_if
// Valid/ready channels of the reliable datagram sequencer: request channel,
// response channel and configuration write channel.
// ----------------------------------------------------------------------------

// Request channel.
interface rds_req_if;
	logic              valid;
	logic              ready;
	rds_pkg::rds_req_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// Response channel.
interface rds_rsp_if;
	logic              valid;
	logic              ready;
	rds_pkg::rds_rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// Configuration write channel.
interface rds_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [rds_pkg::CFG_IDX_W-1:0]  index;
	logic [31:0]                    wdata;

	modport source (output valid, output index, output wdata, input ready);
	modport sink (input valid, input index, input wdata, output ready);
endinterface

>>> rtl/core/reliable_datagram_sequencer.sv
// ----------------------------------------------------------------------------
// reliable_datagram_sequencer
// A request accepted into the input register moves on to the response register,
// where its response waits until the response channel takes it.
// Throughput: one request per cycle while the response channel is ready, set by the single-pass engine stage.
// Reset: arst_n clears configuration and all sequencing state to zero at once.
// ----------------------------------------------------------------------------
module reliable_datagram_sequencer (
	input logic   clk,
	input logic   arst_n,
	rds_req_if.sink   req,
	rds_rsp_if.source rsp,
	rds_cfg_if.sink   cfg
);

	rds_pkg::rds_req_t req_s1;
	logic              vld_s1;
	rds_pkg::rds_rsp_t rsp_s2;
	logic              vld_s2;
	rds_pkg::rds_rsp_t rsp_comb;
	rds_pkg::rds_cfg_t cfg_q;
	logic              adv_s2;
	logic              adv_s1;
	logic              req_fire;

	// Handshake control of the two-register pipeline.
	assign adv_s2    = !vld_s2 || rsp.ready;
	assign adv_s1    = vld_s1 && adv_s2;
	assign req.ready = !vld_s1 || adv_s2;
	assign req_fire  = req.valid && req.ready;
	assign cfg.ready = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				rds_pkg::REG_PEER_IP:        cfg_q.peer_ip        <= cfg.wdata;
				rds_pkg::REG_PEER_PORT:      cfg_q.peer_port      <= cfg.wdata[15:0];
				rds_pkg::REG_CLIENT_PORT_ID: cfg_q.client_port_id <= cfg.wdata[15:0];
				default: ;
			endcase
		end
	end

	// Input register valid and response register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (req_fire) begin
				vld_s1 <= 1'b1;
			end else if (adv_s1) begin
				vld_s1 <= 1'b0;
			end
			if (adv_s2) begin
				vld_s2 <= vld_s1;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (req_fire) begin
			req_s1 <= req.data;
		end
		if (adv_s1) begin
			rsp_s2 <= rsp_comb;
		end
	end

	// Sequencing engine between the two registers.
	rds_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (adv_s1),
		.req    (req_s1),
		.cfg    (cfg_q),
		.rsp    (rsp_comb)
	);

	assign rsp.valid = vld_s2;
	assign rsp.data  = rsp_s2;

endmodule

>>> rtl/core/rds_engine.sv
// ----------------------------------------------------------------------------
// rds_engine
// Sequencing state and the single-pass decision logic. Builds the response
// for the request in the input register and updates the channel state when
// that request moves on to the response register.
// ----------------------------------------------------------------------------
module rds_engine (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  rds_pkg::rds_req_t req,
	input  rds_pkg::rds_cfg_t cfg,
	output rds_pkg::rds_rsp_t rsp
);

	logic [rds_pkg::SEQ_W-1:0] send_seq_q, send_seq_d;
	logic [rds_pkg::SEQ_W-1:0] last_rel_seq_q, last_rel_seq_d;
	logic                      send_rel_flag_q, send_rel_flag_d;
	logic [rds_pkg::SEQ_W-1:0] recv_seq_q, recv_seq_d;
	logic [rds_pkg::SEQ_W-1:0] acked_seq_q, acked_seq_d;
	logic                      acked_flag_q, acked_flag_d;
	logic                      recv_rel_flag_q, recv_rel_flag_d;
	logic [rds_pkg::LEN_W-1:0] rel_len_q, rel_len_d;

	logic                      rel;
	logic                      took;
	logic [rds_pkg::LEN_W-1:0] rbytes;
	logic [rds_pkg::LEN_W-1:0] sat_len;
	logic [rds_pkg::LEN_W:0]   room;
	logic [rds_pkg::SEQ_W-1:0] seq_inc;

	// Pending length saturated to the store size, and the incremented sequence.
	assign sat_len = (req.pending_len > rds_pkg::MAX_MESSAGE) ?
		rds_pkg::MAX_MESSAGE : req.pending_len;
	assign seq_inc = send_seq_q + 31'd1;

	// Decision logic for receive and transmit requests.
	always_comb begin
		send_seq_d      = send_seq_q;
		last_rel_seq_d  = last_rel_seq_q;
		send_rel_flag_d = send_rel_flag_q;
		recv_seq_d      = recv_seq_q;
		acked_seq_d     = acked_seq_q;
		acked_flag_d    = acked_flag_q;
		recv_rel_flag_d = recv_rel_flag_q;
		rel_len_d       = rel_len_q;
		rel             = 1'b0;
		took            = 1'b0;
		rbytes          = '0;
		room            = '0;
		rsp             = '0;

		if (req.func == rds_pkg::FUNC_RECEIVE) begin
			if (req.src_ip != cfg.peer_ip || req.src_port != cfg.peer_port) begin
				rsp.status = rds_pkg::ST_WRONG_SRC;
			end else if (req.seq_word[30:0] <= recv_seq_q) begin
				rsp.status = rds_pkg::ST_STALE;
			end else begin
				rsp.status = rds_pkg::ST_ACCEPTED;
				// The outstanding message is released once its flag comes back.
				if (req.ack_word[31] == send_rel_flag_q) begin
					rel_len_d = '0;
				end
				recv_seq_d   = req.seq_word[30:0];
				acked_seq_d  = req.ack_word[30:0];
				acked_flag_d = req.ack_word[31];
				if (req.seq_word[31]) begin
					recv_rel_flag_d = ~recv_rel_flag_q;
				end
			end
		end else if (req.overflowed) begin
			rsp.status = rds_pkg::ST_OVERFLOW;
		end else begin
			// Resend when the peer has moved past the last reliable send
			// without acknowledging the current flag.
			rel = (acked_seq_q > last_rel_seq_q) && (acked_flag_q != send_rel_flag_q);
			// Latch a new message when the store is empty.
			if (rel_len_q == '0 && req.pending_len != '0) begin
				rel_len_d       = sat_len;
				send_rel_flag_d = ~send_rel_flag_q;
				rel             = 1'b1;
				took            = 1'b1;
			end
			send_seq_d = seq_inc;
			if (rel) begin
				rbytes         = rel_len_d;
				last_rel_seq_d = seq_inc;
			end
			room = {1'b0, rds_pkg::MAX_MESSAGE} - {1'b0, rbytes};

			rsp.status             = (cfg.peer_ip == '0) ? rds_pkg::ST_NO_PEER :
				rds_pkg::ST_SENT;
			rsp.out_seq_word       = {rel, send_seq_q};
			rsp.out_ack_word       = {recv_rel_flag_q, recv_seq_q};
			rsp.out_port_id        = cfg.client_port_id;
			rsp.reliable_bytes     = rbytes;
			rsp.include_unreliable = (req.unreliable_len <= room);
			rsp.took_message       = took;
		end
	end

	// Channel state, updated as the request leaves the input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			send_seq_q      <= '0;
			last_rel_seq_q  <= '0;
			send_rel_flag_q <= 1'b0;
			recv_seq_q      <= '0;
			acked_seq_q     <= '0;
			acked_flag_q    <= 1'b0;
			recv_rel_flag_q <= 1'b0;
			rel_len_q       <= '0;
		end else if (fire) begin
			send_seq_q      <= send_seq_d;
			last_rel_seq_q  <= last_rel_seq_d;
			send_rel_flag_q <= send_rel_flag_d;
			recv_seq_q      <= recv_seq_d;
			acked_seq_q     <= acked_seq_d;
			acked_flag_q    <= acked_flag_d;
			recv_rel_flag_q <= recv_rel_flag_d;
			rel_len_q       <= rel_len_d;
		end
	end

endmodule
